/* design/rls_pkg.sv */
// Shared constants and fixed-point helpers for the stereo RLS filter.
// No dependencies; imported by rls_adaptive_filter_stereo_top.
package rls_pkg;

  localparam int TAPS_DEFAULT = 5;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FORGETTING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAGONAL   = 2'd1;

  localparam logic [31:0] LAMBDA_RESET = 32'd2147268900;
  localparam logic [30:0] DIAG_RESET   = 31'd6553600;

  localparam logic [4:0] DIV_STEPS = 5'd31;

  function automatic logic signed [63:0] rnd15(input logic signed [63:0] v);
    return (v + 64'sd16384) >>> 15;
  endfunction

  function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) begin
      return 16'sh7fff;
    end else if (v < -64'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

/* design/rls_adaptive_filter_stereo_top.sv */
// Stereo RLS adaptive FIR filter: sequencer, shared multiplier, serial
// divider and the inverse-correlation memory. Depends on rls_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one request of four raw 12-bit
//   ADC samples. in_ready is high only while the filter is idle; each
//   request runs the left channel, then the right channel, one at a time.
//   Output channel (out_valid/out_ready) returns estimates, residuals and
//   the converted reference samples from an output register, so a new
//   request is taken while a finished result still waits.
//   Processing time is set by the 31-step restoring divider, run once per gain
//   entry (when the denominator is positive) and once per matrix entry (when
//   lambda is nonzero), and by the single read port of the inverse-correlation
//   memory.
//   Configuration: write_enable/write_index/write_data, only while idle.
//   Writing the diagonal register reloads both matrices at once by clearing
//   per-row valid bits; an invalid row reads as the diagonal pattern.
//   Reset (rst, synchronous) restores the register defaults, zeroes taps and
//   weights and marks all matrix rows invalid. There is no clearing pass.
//   If the receiver stalls, the finished result holds in the output
//   register and the next request waits in its last state until taken.
module rls_adaptive_filter_stereo_top
  import rls_pkg::*;
#(
  parameter int TAPS = TAPS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [11:0]          error_left_raw,
  input  logic [11:0]          error_right_raw,
  input  logic [11:0]          noise_left_raw,
  input  logic [11:0]          noise_right_raw,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   estimate_left,
  output logic signed [15:0]   estimate_right,
  output logic signed [15:0]   residual_left,
  output logic signed [15:0]   residual_right,
  output logic signed [15:0]   noise_left_pcm,
  output logic signed [15:0]   noise_right_pcm,
  input  logic                 write_enable,
  input  logic [CFG_IDX_W-1:0] write_index,
  input  logic [31:0]          write_data
);

  localparam int IW    = $clog2(TAPS);
  localparam int TT    = TAPS * TAPS;
  localparam int SA_W  = $clog2(2 * TT);
  localparam int RW    = $clog2(2 * TAPS);
  localparam logic [IW-1:0] LAST = IW'(TAPS - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_SHIFT, S_EST_MUL, S_EST_ACC, S_EST_END,
    S_PSI_RD, S_PSI_MUL, S_PSI_ACC, S_PSI_END,
    S_DEN_MUL, S_DEN_ACC, S_K_START, S_K_DIV, S_K_END,
    S_UPD_RD, S_UPD_MUL, S_UPD_SUB, S_U_DIV, S_U_END,
    S_GAIN_RD, S_GAIN_MUL, S_GAIN_ACC, S_GAIN_END, S_W_MUL, S_W_UPD,
    S_DONE
  } state_t;

  state_t state;

  logic                ch;
  logic [IW-1:0]       i, j;
  logic [31:0]         lambda;
  logic [30:0]         diag;
  logic [2*TAPS-1:0]   row_valid;

  logic signed [15:0]  err_pcm   [2];
  logic signed [15:0]  noise_pcm [2];
  logic signed [15:0]  est_q     [2];
  logic signed [15:0]  res_q     [2];
  logic signed [15:0]  e_cur;
  logic signed [15:0]  taps      [2][TAPS];
  logic signed [31:0]  weights   [2][TAPS];
  logic signed [31:0]  psi       [TAPS];
  logic signed [31:0]  kg        [TAPS];
  logic signed [31:0]  g;
  logic signed [63:0]  acc;
  logic [63:0]         den;
  logic signed [63:0]  prod;

  // inverse-correlation memory
  logic signed [31:0]  smem [2*TT];
  logic signed [31:0]  srd;
  logic                rvalid_q, rdiag_q;
  logic [SA_W-1:0]     s_addr;
  logic [RW-1:0]       row;
  logic                wr_en;
  logic signed [31:0]  wr_data;
  logic signed [31:0]  s_val;

  // divider
  logic [63:0]         dv_rem, dv_den;
  logic [30:0]         dv_q;
  logic                dv_neg, dv_ovf;
  logic [4:0]          dv_cnt;
  logic                div_load;
  logic signed [31:0]  div_v;
  logic [63:0]         div_d;
  logic [31:0]         div_mag;
  logic [64:0]         rem2;
  logic signed [31:0]  div_res;

  logic signed [31:0]  mul_a, mul_b;
  logic signed [31:0]  x32, wsel, psel, ksel;
  logic [IW-1:0]       wa, pa;
  logic signed [63:0]  y_est, err_d, t_wide;
  logic signed [31:0]  t_sub;
  logic                den_pos, ilast, jlast;

  assign in_ready = (state == S_IDLE);
  assign ilast    = (i == LAST);
  assign jlast    = (j == LAST);
  assign den_pos  = !den[63] && (den != '0);

  assign s_addr = SA_W'(ch) * SA_W'(TT) + SA_W'(i) * SA_W'(TAPS) + SA_W'(j);
  assign row    = RW'(ch) * RW'(TAPS) + RW'(i);
  assign s_val  = rvalid_q ? srd : (rdiag_q ? signed'({1'b0, diag}) : 32'sd0);

  always_comb begin
    wa   = (state == S_W_UPD) ? i : j;
    pa   = (state == S_K_START) ? i : j;
    x32  = 32'(taps[ch][j]);
    wsel = weights[ch][wa];
    psel = psi[pa];
    ksel = kg[i];
    y_est  = rnd16(acc);
    err_d  = 64'(err_pcm[ch]) - y_est;
    t_wide = 64'(s_val) - rnd16(prod);
    t_sub  = sat32(t_wide);
    case (state)
      S_EST_MUL:              begin mul_a = x32;  mul_b = wsel;        end
      S_PSI_MUL, S_GAIN_MUL:  begin mul_a = s_val; mul_b = x32;        end
      S_DEN_MUL:              begin mul_a = psel; mul_b = x32;         end
      S_UPD_MUL:              begin mul_a = ksel; mul_b = psel;        end
      S_W_MUL:                begin mul_a = g;    mul_b = 32'(e_cur);  end
      default:                begin mul_a = '0;   mul_b = '0;          end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  // divider: v * 2^31 / d with the sign of v, magnitude truncated, saturated to 32 bits
  always_comb begin
    div_load = (state == S_K_START && den_pos) || (state == S_UPD_SUB && lambda != '0);
    div_v    = (state == S_K_START) ? psel : t_sub;
    div_d    = (state == S_K_START) ? den : 64'(lambda);
    div_mag  = div_v[31] ? (~div_v + 32'd1) : div_v;
    rem2     = {dv_rem, 1'b0};
    if (dv_ovf) begin
      div_res = dv_neg ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      div_res = dv_neg ? -signed'({1'b0, dv_q}) : signed'({1'b0, dv_q});
    end
    wr_en   = (state == S_UPD_SUB && lambda == '0) || state == S_U_END;
    wr_data = (state == S_U_END) ? div_res : t_sub;
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      dv_rem <= 64'(div_mag);
      dv_den <= div_d;
      dv_ovf <= 64'(div_mag) >= div_d;
      dv_neg <= div_v[31];
      dv_q   <= '0;
      dv_cnt <= DIV_STEPS;
    end else if (state == S_K_DIV || state == S_U_DIV) begin
      if (rem2 >= {1'b0, dv_den}) begin
        dv_rem <= 64'(rem2 - {1'b0, dv_den});
        dv_q   <= {dv_q[29:0], 1'b1};
      end else begin
        dv_rem <= rem2[63:0];
        dv_q   <= {dv_q[29:0], 1'b0};
      end
      dv_cnt <= dv_cnt - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      smem[s_addr] <= wr_data;
    end
    srd      <= smem[s_addr];
    rvalid_q <= row_valid[row];
    rdiag_q  <= (i == j);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      ch        <= 1'b0;
      i         <= '0;
      j         <= '0;
      lambda    <= LAMBDA_RESET;
      diag      <= DIAG_RESET;
      row_valid <= '0;
      for (int c = 0; c < 2; c++) begin
        for (int k = 0; k < TAPS; k++) begin
          taps[c][k]    <= '0;
          weights[c][k] <= '0;
        end
      end
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            err_pcm[0]   <= {~error_left_raw[11], error_left_raw[10:0], 4'b0};
            err_pcm[1]   <= {~error_right_raw[11], error_right_raw[10:0], 4'b0};
            noise_pcm[0] <= {~noise_left_raw[11], noise_left_raw[10:0], 4'b0};
            noise_pcm[1] <= {~noise_right_raw[11], noise_right_raw[10:0], 4'b0};
            ch    <= 1'b0;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          for (int k = TAPS - 1; k > 0; k--) begin
            taps[ch][k] <= taps[ch][k-1];
          end
          taps[ch][0] <= noise_pcm[ch];
          acc   <= '0;
          i     <= '0;
          j     <= '0;
          state <= S_EST_MUL;
        end
        S_EST_MUL: state <= S_EST_ACC;
        S_EST_ACC: begin
          acc <= acc + prod;
          if (jlast) begin
            state <= S_EST_END;
          end else begin
            j     <= j + 1'b1;
            state <= S_EST_MUL;
          end
        end
        S_EST_END: begin
          est_q[ch] <= sat16(y_est);
          res_q[ch] <= sat16(err_d);
          e_cur     <= sat16(err_d);
          acc   <= '0;
          i     <= '0;
          j     <= '0;
          state <= S_PSI_RD;
        end
        S_PSI_RD:  state <= S_PSI_MUL;
        S_PSI_MUL: state <= S_PSI_ACC;
        S_PSI_ACC: begin
          acc <= acc + prod;
          if (jlast) begin
            state <= S_PSI_END;
          end else begin
            j     <= j + 1'b1;
            state <= S_PSI_RD;
          end
        end
        S_PSI_END: begin
          psi[i] <= sat32(rnd15(acc));
          j      <= '0;
          if (ilast) begin
            acc   <= 64'(lambda);
            state <= S_DEN_MUL;
          end else begin
            acc   <= '0;
            i     <= i + 1'b1;
            state <= S_PSI_RD;
          end
        end
        S_DEN_MUL: state <= S_DEN_ACC;
        S_DEN_ACC: begin
          acc <= acc + prod;
          if (jlast) begin
            den   <= acc + prod;
            i     <= '0;
            j     <= '0;
            state <= S_K_START;
          end else begin
            j     <= j + 1'b1;
            state <= S_DEN_MUL;
          end
        end
        S_K_START: begin
          if (den_pos) begin
            state <= S_K_DIV;
          end else begin
            kg[i] <= '0;
            if (ilast) begin
              i     <= '0;
              state <= S_UPD_RD;
            end else begin
              i     <= i + 1'b1;
              state <= S_K_START;
            end
          end
        end
        S_K_DIV: begin
          if (dv_cnt == 5'd1) begin
            state <= S_K_END;
          end
        end
        S_K_END: begin
          kg[i] <= div_res;
          if (ilast) begin
            i     <= '0;
            state <= S_UPD_RD;
          end else begin
            i     <= i + 1'b1;
            state <= S_K_START;
          end
        end
        S_UPD_RD:  state <= S_UPD_MUL;
        S_UPD_MUL: state <= S_UPD_SUB;
        S_UPD_SUB, S_U_END: begin
          if (state == S_UPD_SUB && lambda != '0) begin
            state <= S_U_DIV;
          end else if (jlast) begin
            row_valid[row] <= 1'b1;
            j <= '0;
            if (ilast) begin
              i     <= '0;
              acc   <= '0;
              state <= S_GAIN_RD;
            end else begin
              i     <= i + 1'b1;
              state <= S_UPD_RD;
            end
          end else begin
            j     <= j + 1'b1;
            state <= S_UPD_RD;
          end
        end
        S_U_DIV: begin
          if (dv_cnt == 5'd1) begin
            state <= S_U_END;
          end
        end
        S_GAIN_RD:  state <= S_GAIN_MUL;
        S_GAIN_MUL: state <= S_GAIN_ACC;
        S_GAIN_ACC: begin
          acc <= acc + prod;
          if (jlast) begin
            state <= S_GAIN_END;
          end else begin
            j     <= j + 1'b1;
            state <= S_GAIN_RD;
          end
        end
        S_GAIN_END: begin
          g     <= sat32(rnd15(acc));
          state <= S_W_MUL;
        end
        S_W_MUL: state <= S_W_UPD;
        S_W_UPD: begin
          weights[ch][i] <= sat32(64'(wsel) + rnd15(prod));
          acc <= '0;
          j   <= '0;
          if (ilast) begin
            i <= '0;
            if (ch) begin
              state <= S_DONE;
            end else begin
              ch    <= 1'b1;
              state <= S_SHIFT;
            end
          end else begin
            i     <= i + 1'b1;
            state <= S_GAIN_RD;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            estimate_left   <= est_q[0];
            estimate_right  <= est_q[1];
            residual_left   <= res_q[0];
            residual_right  <= res_q[1];
            noise_left_pcm  <= noise_pcm[0];
            noise_right_pcm <= noise_pcm[1];
            out_valid <= 1'b1;
            ch        <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (write_enable) begin
        case (write_index)
          CFG_FORGETTING: lambda <= write_data;
          CFG_DIAGONAL: begin
            diag      <= write_data[30:0];
            row_valid <= '0;
          end
          default: ;
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_done_publishes: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && (!out_valid || out_ready) |=> out_valid && state == S_IDLE)
    else $error("result not published");

  a_div_load_state: assert property (@(posedge clk) disable iff (rst)
    div_load |-> (state == S_K_START || state == S_UPD_SUB))
    else $error("divider loaded outside gain or update");

  a_div_running: assert property (@(posedge clk) disable iff (rst)
    (state == S_K_DIV || state == S_U_DIV) |-> dv_cnt != 5'd0)
    else $error("divider step with empty count");

  a_diag_reload: assert property (@(posedge clk) disable iff (rst)
    write_enable && write_index == CFG_DIAGONAL |=> row_valid == '0)
    else $error("diagonal write did not invalidate rows");
`endif

endmodule
